// ----- sv/mie_pkg.sv -----
// mie_pkg: shared types, constants and modular helpers for the modular inverse block
// used by mie_ctrl, mie_datapath and modular_inverse_euclid
`default_nettype none

package mie_pkg;

   localparam int WIDTH = 16;
   localparam int CNT_W = $clog2(WIDTH);

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_DIVIDE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;         // capture value, start reduction by modulus
      logic div_step;     // one restoring division bit
      logic init_euclid;  // r0 = m, r1 = a, t0 = 0, t1 = 1, start first division
      logic update;       // shift the euclid state, start next division
      logic emit_fail;    // present a no-inverse result
      logic emit_result;  // present the final result
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic last_bit;   // division on its final bit
      logic rem_zero;   // division remainder is zero
      logic mod_small;  // modulus below two
   } status_type;

   // (x + y) mod m with x, y below m
   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                                input logic [WIDTH-1:0] y,
                                                input logic [WIDTH-1:0] m);
      logic [WIDTH-1:0] gap;
      gap = m - y;
      add_mod = (x >= gap) ? x - gap : x + y;
   endfunction

   // (x - y) mod m with x, y below m
   function automatic logic [WIDTH-1:0] sub_mod(input logic [WIDTH-1:0] x,
                                                input logic [WIDTH-1:0] y,
                                                input logic [WIDTH-1:0] m);
      sub_mod = (x >= y) ? x - y : x + (m - y);
   endfunction

endpackage

`default_nettype wire

// ----- sv/mie_ctrl.sv -----
// mie_ctrl: state machine sequencing reduction, euclid steps and result
// depends on mie_pkg
`default_nettype none

module mie_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire mie_pkg::status_type status,
   output logic                     busy,
   output mie_pkg::cmd_type         cmd
);

   mie_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mie_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         mie_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = mie_pkg::ST_REDUCE;
            end
         end
         mie_pkg::ST_REDUCE: begin
            cmd.div_step = 1'b1;
            if (status.last_bit) begin
               state_in = mie_pkg::ST_CHECK;
            end
         end
         mie_pkg::ST_CHECK: begin
            // reduced value now in the remainder
            if (status.mod_small || status.rem_zero) begin
               cmd.emit_fail = 1'b1;
               state_in      = mie_pkg::ST_IDLE;
            end else begin
               cmd.init_euclid = 1'b1;
               state_in        = mie_pkg::ST_DIVIDE;
            end
         end
         mie_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.last_bit) begin
               state_in = mie_pkg::ST_UPDATE;
            end
         end
         mie_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.rem_zero ? mie_pkg::ST_FINISH : mie_pkg::ST_DIVIDE;
         end
         mie_pkg::ST_FINISH: begin
            cmd.emit_result = 1'b1;
            state_in        = mie_pkg::ST_IDLE;
         end
         default: begin
            state_in = mie_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/mie_datapath.sv -----
// mie_datapath: modulus register, bit-serial divider, coefficient accumulator and result
// depends on mie_pkg
`default_nettype none

module mie_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [mie_pkg::WIDTH-1:0]  csr_write_data,
   input  wire logic [mie_pkg::WIDTH-1:0]  req_value,
   input  wire mie_pkg::cmd_type           cmd,
   output mie_pkg::status_type             status,
   output logic                            rsp_valid,
   output logic [mie_pkg::WIDTH-1:0]       rsp_inverse,
   output logic                            rsp_no_inverse
);

   localparam int W = mie_pkg::WIDTH;

   logic [W-1:0]                modulus_ff;
   logic [W-1:0]                r0_ff, r1_ff, t0_ff, t1_ff;
   logic [W-1:0]                dividend_ff, divisor_ff, rem_ff, acc_ff;
   logic [mie_pkg::CNT_W-1:0]   cnt_ff;
   logic                        valid_ff;
   logic [W-1:0]                inverse_ff;
   logic                        no_inverse_ff;

   logic [W:0]                  trial;
   logic                        q_bit;
   logic [W-1:0]                rem_in;
   logic [W-1:0]                acc_dbl;
   logic [W-1:0]                acc_in;
   logic [W-1:0]                t2;

   // modulus register
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= W'(2);
      end else if (csr_write_enable) begin
         modulus_ff <= csr_write_data;
      end
   end

   // one restoring division bit, quotient folded into q * t1 mod m msb first
   always_comb begin
      trial   = {rem_ff, dividend_ff[W-1]};
      q_bit   = (trial >= {1'b0, divisor_ff});
      rem_in  = q_bit ? W'(trial - {1'b0, divisor_ff}) : trial[W-1:0];
      acc_dbl = mie_pkg::add_mod(acc_ff, acc_ff, modulus_ff);
      acc_in  = q_bit ? mie_pkg::add_mod(acc_dbl, t1_ff, modulus_ff) : acc_dbl;
      t2      = mie_pkg::sub_mod(t0_ff, acc_ff, modulus_ff);
   end

   // divider and euclid state
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dividend_ff <= req_value;
         divisor_ff  <= modulus_ff;
         rem_ff      <= '0;
         acc_ff      <= '0;
         cnt_ff      <= '0;
      end else if (cmd.div_step) begin
         dividend_ff <= {dividend_ff[W-2:0], 1'b0};
         rem_ff      <= rem_in;
         acc_ff      <= acc_in;
         cnt_ff      <= cnt_ff + 1'b1;
      end else if (cmd.init_euclid) begin
         r0_ff       <= modulus_ff;
         r1_ff       <= rem_ff;
         t0_ff       <= '0;
         t1_ff       <= W'(1);
         dividend_ff <= modulus_ff;
         divisor_ff  <= rem_ff;
         rem_ff      <= '0;
         acc_ff      <= '0;
         cnt_ff      <= '0;
      end else if (cmd.update) begin
         r0_ff       <= r1_ff;
         r1_ff       <= rem_ff;
         t0_ff       <= t1_ff;
         t1_ff       <= t2;
         dividend_ff <= r1_ff;
         divisor_ff  <= rem_ff;
         rem_ff      <= '0;
         acc_ff      <= '0;
         cnt_ff      <= '0;
      end
   end

   // result register, strobe for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit_fail | cmd.emit_result;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_fail) begin
         inverse_ff    <= '0;
         no_inverse_ff <= 1'b1;
      end else if (cmd.emit_result) begin
         inverse_ff    <= (r0_ff == W'(1)) ? t0_ff : '0;
         no_inverse_ff <= (r0_ff != W'(1));
      end
   end

   // status to controller
   always_comb begin
      status.last_bit  = (cnt_ff == mie_pkg::CNT_W'(W - 1));
      status.rem_zero  = (rem_ff == '0);
      status.mod_small = (modulus_ff < W'(2));
   end

   assign rsp_valid      = valid_ff;
   assign rsp_inverse    = inverse_ff;
   assign rsp_no_inverse = no_inverse_ff;

endmodule

`default_nettype wire

// ----- sv/modular_inverse_euclid.sv -----
// modular_inverse_euclid: top level of the extended euclidean modular inverse
// depends on mie_pkg, mie_ctrl, mie_datapath
//
// Usage:
//   csr_write_enable / csr_write_data write the 16-bit modulus (reset value 2).
//   Write it only while busy is low and no result is outstanding.
//   A transaction is taken at a rising edge with start high and busy low;
//   req_value is sampled there and reduced modulo the modulus first.
//   One result per transaction: rsp_valid is high for exactly one cycle with
//   rsp_inverse and rsp_no_inverse; the receiver cannot stall it.
// Sequence:
//   reduction runs through the bit-serial divider, and each euclid step is a
//   full division through it followed by an update. A value that reduces
//   to zero gives its no-inverse result from the check after the reduction;
//   otherwise the result follows the last euclid step (there are at most
//   about 23 euclid steps for 16 bits).
//   busy drops as the result appears, so the next start may be taken then.
// Reset:
//   synchronous, active high; returns the controller to idle, clears the
//   result strobe and sets the modulus to 2.
`default_nettype none

module modular_inverse_euclid (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [mie_pkg::WIDTH-1:0]  csr_write_data,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [mie_pkg::WIDTH-1:0]  req_value,
   output logic                            rsp_valid,
   output logic [mie_pkg::WIDTH-1:0]       rsp_inverse,
   output logic                            rsp_no_inverse
);

   mie_pkg::cmd_type    cmd;
   mie_pkg::status_type status;

   // sequencing
   mie_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // arithmetic and result registers
   mie_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_value        (req_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_inverse      (rsp_inverse),
      .rsp_no_inverse   (rsp_no_inverse)
   );

endmodule

`default_nettype wire

// ----- dv/tb_modular_inverse_euclid.sv -----
// tb_modular_inverse_euclid: self-checking testbench for the euclidean modular inverse
// drives directed and random transactions under several moduli, checks every result
// depends on mie_pkg and modular_inverse_euclid
`timescale 1ns / 1ps

module tb_modular_inverse_euclid;

   localparam int W = mie_pkg::WIDTH;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES = 450;

   typedef enum logic [1:0] {
      ITEM_VALUE,
      ITEM_MODULUS,
      ITEM_DRAIN
   } item_kind_type;

   typedef struct packed {
      item_kind_type  kind;
      logic [W-1:0]   data;
   } pending_item_type;

   typedef struct packed {
      logic [W-1:0]   inverse;
      logic           no_inverse;
   } inverse_result_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           csr_write_enable = 1'b0;
   logic [W-1:0]   csr_write_data = '0;
   logic           start = 1'b0;
   logic           busy;
   logic [W-1:0]   req_value = '0;
   logic           rsp_valid;
   logic [W-1:0]   rsp_inverse;
   logic           rsp_no_inverse;

   pending_item_type    pending_q [$];
   inverse_result_type  inverse_q [$];
   logic [W-1:0]        modulus_copy = 2;
   int                  gap_left = 0;
   int                  accepted_count = 0;
   int                  mismatch_count = 0;
   int                  quiet_cycles = 0;

   modular_inverse_euclid dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_inverse      (rsp_inverse),
      .rsp_no_inverse   (rsp_no_inverse)
   );

   always #5 clock = ~clock;

   // inverse of value modulo m by the extended euclidean algorithm,
   // bezout coefficient kept reduced modulo m
   function automatic inverse_result_type predict_inverse(logic [W-1:0] value,
                                                          logic [W-1:0] m);
      inverse_result_type  res;
      logic [W-1:0]        a, r0, r1, r2, q, t0, t1, t2, qt;
      logic [2*W-1:0]      prod;
      res.inverse = '0;
      res.no_inverse = 1'b1;
      if (m < 2)
         return res;
      a = value % m;
      if (a == 0)
         return res;
      r0 = m;
      r1 = a;
      t0 = '0;
      t1 = W'(1);
      while (r1 != 0) begin
         q = r0 / r1;
         r2 = r0 - q * r1;
         prod = {{W{1'b0}}, t1} * {{W{1'b0}}, q};
         qt = W'(prod % {{W{1'b0}}, m});
         t2 = (t0 >= qt) ? t0 - qt : t0 + (m - qt);
         r0 = r1;
         r1 = r2;
         t0 = t1;
         t1 = t2;
      end
      if (r0 == 1) begin
         res.inverse = t0;
         res.no_inverse = 1'b0;
      end
      return res;
   endfunction

   // idle time before the next transaction: bursts with none, else mostly short
   function automatic int choose_gap(int n);
      int roll;
      if ((n % 160) < 40)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 20);
      else
         return $urandom_range(50, 400);
   endfunction

   // random value biased towards the interesting region of the modulus
   function automatic logic [W-1:0] pick_value(logic [W-1:0] m);
      case ($urandom_range(0, 9))
         4:       return $urandom_range(0, 7);
         5:       return m + $urandom_range(0, 3) - 2;
         6:       return m * $urandom_range(0, 4);
         7:       return $urandom_range(1, 8) * $urandom_range(0, 8000);
         8:       return {W{1'b1}} - $urandom_range(0, 3);
         9:       return $urandom_range(0, m);
         default: return $urandom_range(0, (1 << W) - 1);
      endcase
   endfunction

   // append one entry to the stimulus queue
   task automatic queue_item(item_kind_type kind, logic [W-1:0] data);
      pending_q.insert(pending_q.size(), pending_item_type'{kind, data});
   endtask

   task automatic add_value(logic [W-1:0] value);
      queue_item(ITEM_VALUE, value);
   endtask

   task automatic add_modulus(logic [W-1:0] m);
      queue_item(ITEM_MODULUS, m);
   endtask

   task automatic add_drain();
      queue_item(ITEM_DRAIN, '0);
   endtask

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // driver: presents queued transactions and modulus writes, predicts on acceptance
   always @(posedge clock) begin : driver
      logic              nxt_start;
      logic [W-1:0]      nxt_value;
      logic              nxt_we;
      logic [W-1:0]      nxt_data;
      pending_item_type  item;
      nxt_start = start;
      nxt_value = req_value;
      nxt_we = 1'b0;
      nxt_data = csr_write_data;
      if (reset) begin
         nxt_start = 1'b0;
         gap_left = 0;
         modulus_copy = 2;
      end else begin
         if (start && !busy) begin
            inverse_q.insert(inverse_q.size(), predict_inverse(req_value, modulus_copy));
            accepted_count++;
            nxt_start = 1'b0;
            gap_left = choose_gap(accepted_count);
         end
         if (!nxt_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_q.size() != 0) begin
               item = pending_q[0];
               case (item.kind)
                  ITEM_VALUE: begin
                     nxt_start = 1'b1;
                     nxt_value = item.data;
                     void'(pending_q.pop_front());
                  end
                  ITEM_MODULUS: begin
                     // only with the block idle and nothing outstanding
                     if (inverse_q.size() == 0 && !rsp_valid && !busy) begin
                        nxt_we = 1'b1;
                        nxt_data = item.data;
                        modulus_copy = item.data;
                        void'(pending_q.pop_front());
                     end
                  end
                  default: begin
                     if (inverse_q.size() == 0 && !rsp_valid)
                        void'(pending_q.pop_front());
                  end
               endcase
            end
         end
      end
      start <= nxt_start;
      req_value <= nxt_value;
      csr_write_enable <= nxt_we;
      csr_write_data <= nxt_data;
   end

   // monitor: each result against the oldest prediction
   always @(posedge clock) begin : monitor
      inverse_result_type want;
      if (!reset && rsp_valid) begin
         if (inverse_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing outstanding: inverse %0d flag %0d",
                                      rsp_inverse, rsp_no_inverse));
         end else begin
            want = inverse_q.pop_front();
            if (rsp_inverse !== want.inverse)
               report_mismatch($sformatf("inverse got %0d expected %0d",
                                         rsp_inverse, want.inverse));
            if (rsp_no_inverse !== want.no_inverse)
               report_mismatch($sformatf("no_inverse got %0d expected %0d",
                                         rsp_no_inverse, want.no_inverse));
         end
      end
   end

   // watchdog: cycles with no transaction, result or register write
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_enable)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
         $display("FAIL modular_inverse_euclid");
         $finish;
      end
   end

   initial begin
      logic [W-1:0] phase_mod [$];
      logic [W-1:0] m;
      int           count;

      // directed: reset modulus of two
      add_value(0);
      add_value(1);
      add_value(2);
      add_value(3);
      add_value(16'hFFFF);
      // largest 16-bit prime: zero, one, reduction and long euclid chains
      add_modulus(65521);
      add_value(0);
      add_value(1);
      add_value(2);
      add_value(3);
      add_value(65520);
      add_value(65521);
      add_value(65522);
      add_value(16'hFFFF);
      add_value(40000);
      add_drain();
      // largest modulus, composite: shared factors and coprime values
      add_modulus(16'hFFFF);
      add_value(3);
      add_value(5);
      add_value(2);
      add_value(65534);
      add_value(16'hFFFF);
      add_value(0);
      add_value(256);
      // degenerate moduli below two
      add_modulus(0);
      add_value(5);
      add_value(0);
      add_modulus(1);
      add_value(7);

      // random phases, each under its own modulus
      phase_mod = '{65521, 2, 16'hFFFF, 3, 32768, 7919, 1000, 1, 0, 251};
      phase_mod.insert(phase_mod.size(), $urandom_range(2, (1 << W) - 1));
      phase_mod.insert(phase_mod.size(), $urandom_range(2, (1 << W) - 1) | 1);
      phase_mod.insert(phase_mod.size(), $urandom_range(2, 300));
      foreach (phase_mod[p]) begin
         m = phase_mod[p];
         count = (m < 2) ? 20 : 100;
         add_modulus(m);
         for (int i = 0; i < count; i++) begin
            if (i == count / 2)
               add_drain();
            add_value(pick_value(m));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // wait for all transactions and results, then a tail for stray results
      do
         @(negedge clock);
      while (pending_q.size() != 0 || start || inverse_q.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && inverse_q.size() == 0)
         $display("PASS modular_inverse_euclid");
      else
         $display("FAIL modular_inverse_euclid");
      $finish;
   end

endmodule
